### hw/rtl/swbs_pkg.sv
`timescale 1ns / 1ps

package swbs_pkg;

  // default sizing
  localparam int DEF_MAX_WORDS   = 1024;
  localparam int DEF_WORD_CHUNKS = 4;

  // fixed field widths
  localparam int CHUNK_BITS = 64;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 3;
  localparam int INDEX_W    = 10;

  // input op codes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd4;

  // commands passed from front end to search engine
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_LOAD  = 2'd0;
  localparam cmd_t CMD_QUERY = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;
  localparam cmd_t CMD_LONG  = 2'd3;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic [CHUNK_BITS-1:0] text_chunk;
    logic                  last_chunk;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  found_index;
  } out_word_t;

endpackage

### hw/rtl/sorted_word_binary_search.sv
`timescale 1ns / 1ps
// load result: after the command queue and S_IDLE, S_STORE makes one table write per chunk
// query result: at worst P = ceil(log2(count + 1)) probes, each an S_PROBE step then S_CMP,
//   through the single read port of the word table, one chunk compared per cycle
// front end takes one chunk per cycle while busy is low; busy rises while two commands wait for the engine
// synchronous active-low reset empties the table and drops any partly assembled word
// results appear for one cycle on out_valid and cannot be stalled
module sorted_word_binary_search #(
  parameter int MAX_WORDS   = swbs_pkg::DEF_MAX_WORDS,
  parameter int WORD_CHUNKS = swbs_pkg::DEF_WORD_CHUNKS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  swbs_pkg::in_word_t  in_word,
  output logic                out_valid,
  output swbs_pkg::out_word_t out_word
);
  import swbs_pkg::*;

  cmd_req_t                               push_req, head;
  logic [WORD_CHUNKS-1:0][CHUNK_BITS-1:0] push_key, head_key;
  logic                                   q_full, pop;

  assign busy = q_full;

  // word assembly and classification
  swbs_front #(
    .WORD_CHUNKS(WORD_CHUNKS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (start && !busy),
    .in_word (in_word),
    .req     (push_req),
    .req_key (push_key)
  );

  // command queue
  swbs_queue #(
    .WORD_CHUNKS(WORD_CHUNKS)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_req (push_req),
    .push_key (push_key),
    .pop      (pop),
    .head     (head),
    .head_key (head_key),
    .full     (q_full)
  );

  // table store and binary search engine
  swbs_back #(
    .MAX_WORDS  (MAX_WORDS),
    .WORD_CHUNKS(WORD_CHUNKS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .head_key  (head_key),
    .pop       (pop),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

### hw/rtl/swbs_front.sv
`timescale 1ns / 1ps

module swbs_front #(
  parameter int WORD_CHUNKS = swbs_pkg::DEF_WORD_CHUNKS
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     accept,
  input  swbs_pkg::in_word_t                       in_word,
  output swbs_pkg::cmd_req_t                       req,
  output logic [WORD_CHUNKS-1:0][swbs_pkg::CHUNK_BITS-1:0] req_key
);
  import swbs_pkg::*;

  localparam int POS_W = $clog2(WORD_CHUNKS + 1);

  logic [POS_W-1:0]                       pos_r, pos_nxt;
  logic [WORD_CHUNKS-1:0][CHUNK_BITS-1:0] key_r, key_nxt, key_ins;
  logic                                   long_r, long_nxt;
  logic                                   ovf;

  // assemble chunks and classify the finished word
  always_comb begin
    pos_nxt  = pos_r;
    key_nxt  = key_r;
    long_nxt = long_r;
    req      = '{valid: 1'b0, cmd: CMD_CLEAR};
    key_ins  = key_r;
    ovf      = long_r;
    for (int i = 0; i < WORD_CHUNKS; i++) begin
      if (pos_r == POS_W'(i)) key_ins[i] = in_word.text_chunk;
    end
    if (pos_r == POS_W'(WORD_CHUNKS)) ovf = 1'b1;
    req_key = key_ins;
    if (accept) begin
      case (in_word.op)
        OP_CLEAR: begin
          pos_nxt   = '0;
          key_nxt   = '0;
          long_nxt  = 1'b0;
          req.valid = 1'b1;
          req.cmd   = CMD_CLEAR;
        end
        OP_LOAD, OP_QUERY: begin
          if (in_word.last_chunk) begin
            req.valid = 1'b1;
            if (ovf) req.cmd = CMD_LONG;
            else if (in_word.op == OP_LOAD) req.cmd = CMD_LOAD;
            else req.cmd = CMD_QUERY;
            pos_nxt  = '0;
            key_nxt  = '0;
            long_nxt = 1'b0;
          end else begin
            key_nxt  = key_ins;
            long_nxt = ovf;
            if (!ovf) pos_nxt = pos_r + POS_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      key_r  <= '0;
      long_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      key_r  <= key_nxt;
      long_r <= long_nxt;
    end
  end

  // chunk position saturates at the word size
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(WORD_CHUNKS))
    else $error("chunk position beyond word size");

endmodule

### hw/rtl/swbs_queue.sv
`timescale 1ns / 1ps

module swbs_queue #(
  parameter int WORD_CHUNKS = swbs_pkg::DEF_WORD_CHUNKS
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  swbs_pkg::cmd_req_t                               push_req,
  input  logic [WORD_CHUNKS-1:0][swbs_pkg::CHUNK_BITS-1:0] push_key,
  input  logic                                             pop,
  output swbs_pkg::cmd_req_t                               head,
  output logic [WORD_CHUNKS-1:0][swbs_pkg::CHUNK_BITS-1:0] head_key,
  output logic                                             full
);
  import swbs_pkg::*;

  logic [WORD_CHUNKS-1:0][CHUNK_BITS-1:0] key_q [2];
  cmd_t                                   cmd_q [2];
  logic                                   wr_ptr_r, rd_ptr_r;
  logic [1:0]                             cnt_r, cnt_nxt;
  logic                                   do_pop;

  // two-entry fifo between front end and engine
  assign full     = (cnt_r == 2'd2);
  assign do_pop   = pop && (cnt_r != 2'd0);
  assign head     = '{valid: (cnt_r != 2'd0), cmd: cmd_q[rd_ptr_r]};
  assign head_key = key_q[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_req.valid && !do_pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push_req.valid && do_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push_req.valid) begin
      key_q[wr_ptr_r] <= push_key;
      cmd_q[wr_ptr_r] <= push_req.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_req.valid) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  // never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push_req.valid)
    else $error("push into full queue");

endmodule

### hw/rtl/swbs_back.sv
`timescale 1ns / 1ps

module swbs_back #(
  parameter int MAX_WORDS   = swbs_pkg::DEF_MAX_WORDS,
  parameter int WORD_CHUNKS = swbs_pkg::DEF_WORD_CHUNKS
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  swbs_pkg::cmd_req_t                               head,
  input  logic [WORD_CHUNKS-1:0][swbs_pkg::CHUNK_BITS-1:0] head_key,
  output logic                                             pop,
  output logic                                             out_valid,
  output swbs_pkg::out_word_t                              out_word
);
  import swbs_pkg::*;

  localparam int IDX_W     = $clog2(MAX_WORDS);
  localparam int CNT_W     = $clog2(MAX_WORDS + 1);
  localparam int CHUNK_W   = (WORD_CHUNKS > 1) ? $clog2(WORD_CHUNKS) : 1;
  localparam int ADDR_W    = IDX_W + CHUNK_W;
  localparam int MEM_DEPTH = MAX_WORDS * (1 << CHUNK_W);
  localparam logic [CHUNK_W-1:0] LAST_CHUNK = CHUNK_W'(WORD_CHUNKS - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_STORE = 2'd1;
  localparam logic [1:0] S_PROBE = 2'd2;
  localparam logic [1:0] S_CMP   = 2'd3;

  logic [CHUNK_BITS-1:0]                  mem [MEM_DEPTH];
  logic [CHUNK_BITS-1:0]                  rdata_r;
  logic [1:0]                             state_r, state_nxt;
  logic [CNT_W-1:0]                       cnt_r, cnt_nxt;
  logic [CNT_W-1:0]                       lo_r, lo_nxt, hi_r, hi_nxt;
  logic [IDX_W-1:0]                       mid_r, mid_nxt, mid;
  logic [CNT_W:0]                         mid_sum;
  logic [CHUNK_W-1:0]                     chunk_r, chunk_nxt;
  logic [WORD_CHUNKS-1:0][CHUNK_BITS-1:0] key_r, key_nxt;
  logic [CHUNK_BITS-1:0]                  key_c;
  logic                                   out_valid_r, out_valid_nxt;
  out_word_t                              out_word_r, out_word_nxt;
  logic                                   mem_we;
  logic [ADDR_W-1:0]                      wr_addr, rd_addr;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign key_c     = key_r[chunk_r];
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r} - (CNT_W + 1)'(1);
  assign mid       = IDX_W'(mid_sum >> 1);

  // command sequencer: clear the table, report too-long or full, store chunks, or halve the search range per probe
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    chunk_nxt     = chunk_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    pop           = 1'b0;
    mem_we        = 1'b0;
    wr_addr       = {cnt_r[IDX_W-1:0], chunk_r};
    rd_addr       = {mid_r, chunk_r};
    case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          case (head.cmd)
            CMD_CLEAR: cnt_nxt = '0;
            CMD_LONG: begin
              out_valid_nxt = 1'b1;
              out_word_nxt  = '{status: ST_TOO_LONG, found_index: '0};
            end
            CMD_LOAD: begin
              if (cnt_r >= CNT_W'(MAX_WORDS)) begin
                out_valid_nxt = 1'b1;
                out_word_nxt  = '{status: ST_FULL, found_index: '0};
              end else begin
                key_nxt   = head_key;
                chunk_nxt = '0;
                state_nxt = S_STORE;
              end
            end
            CMD_QUERY: begin
              key_nxt   = head_key;
              lo_nxt    = '0;
              hi_nxt    = cnt_r;
              state_nxt = S_PROBE;
            end
            default: begin
            end
          endcase
        end
      end
      S_STORE: begin
        mem_we = 1'b1;
        if (chunk_r == LAST_CHUNK) begin
          cnt_nxt       = cnt_r + CNT_W'(1);
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{status: ST_STORED, found_index: '0};
          state_nxt     = S_IDLE;
        end else begin
          chunk_nxt = chunk_r + CHUNK_W'(1);
        end
      end
      S_PROBE: begin
        if (lo_r >= hi_r) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{status: ST_NOT_FOUND, found_index: '0};
          state_nxt     = S_IDLE;
        end else begin
          mid_nxt   = mid;
          chunk_nxt = '0;
          rd_addr   = {mid, {CHUNK_W{1'b0}}};
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (key_c < rdata_r) begin
          hi_nxt    = CNT_W'(mid_r);
          state_nxt = S_PROBE;
        end else if (key_c > rdata_r) begin
          lo_nxt    = CNT_W'(mid_r) + CNT_W'(1);
          state_nxt = S_PROBE;
        end else if (chunk_r == LAST_CHUNK) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{status: ST_FOUND, found_index: INDEX_W'(mid_r)};
          state_nxt     = S_IDLE;
        end else begin
          chunk_nxt = chunk_r + CHUNK_W'(1);
          rd_addr   = {mid_r, chunk_r + CHUNK_W'(1)};
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // word table, one chunk per entry
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= key_c;
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      lo_r        <= '0;
      hi_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mid_r      <= mid_nxt;
    chunk_r    <= chunk_nxt;
    key_r      <= key_nxt;
    out_word_r <= out_word_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_WORDS))
    else $error("word count beyond table size");

  a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PROBE |-> lo_r <= hi_r)
    else $error("search bounds crossed");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result strobe while engine busy");

  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (CNT_W'(mid_r) < hi_r) && (CNT_W'(mid_r) >= lo_r))
    else $error("probe outside search bounds");

endmodule
